// File: src/stpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stpg_pkg
// shared types and constants of the slot table pulse generator
// ----------------------------------------------------------------------------
package stpg_pkg;

  // slot table depth and the widths that follow from it
  localparam int MAX_SLOTS     = 256;
  localparam int SLOT_W        = $clog2(MAX_SLOTS);
  localparam int CNT_W         = $clog2(MAX_SLOTS + 1);

  // pin and level widths
  localparam int PIN_COUNT_DEF = 32;
  localparam int PIN_W         = 5;
  localparam int LEVEL_W       = 32;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_PULSE  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_REPEAT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LEN   = 2'd1,
    ST_START = 2'd2,
    ST_SUB   = 2'd3
  } status_t;

  typedef struct packed {
    op_t                op;
    logic [PIN_W-1:0]   pin;
    logic [SLOT_W-1:0]  start_slot;
    logic [CNT_W-1:0]   length_slots;
    logic [CNT_W-1:0]   sub_period_slots;
  } req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] pin_levels;
    logic [SLOT_W-1:0]  slot;
    status_t            status;
  } res_t;

endpackage
`default_nettype wire

// File: src/slot_table_pulse_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slot_table_pulse_generator_top
// time slot pulse pattern table driving up to 32 output pins
// ----------------------------------------------------------------------------
// tick requests: the slot table read is registered, then the level update loads
//   the output register; one tick per cycle while the output is not stalled
// pulse edit: walks slots_in_use entries, a repeated pulse runs the remainder
//   check first, clear pin walks all MAX_SLOTS entries; one table entry is read
//   and written back per cycle
// reset: synchronous; levels, slot counter and slot register return to their
//   defaults, then a pass over all MAX_SLOTS entries zeroes the table with requests stalled
module slot_table_pulse_generator_top
  import stpg_pkg::*;
#(
  parameter int PIN_COUNT = PIN_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // request channel
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  // result channel
  output logic             res_valid,
  input  logic             res_stall,
  output res_t             res,
  // slots_in_use register
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data
);

  // each table entry holds the set mask above the clear mask
  localparam int ENTRY_W = 2 * PIN_COUNT;
  localparam int DIV_CW  = $clog2(CNT_W);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DRAIN,
    S_DIV,
    S_CHECK,
    S_WALK,
    S_FLUSH,
    S_DONE
  } state_t;

  // what one walk step does to the edited pin in one slot
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_SET,
    ACT_MID,
    ACT_END
  } act_t;

  state_t                state;
  logic [CNT_W-1:0]      slots_in_use;
  logic [SLOT_W-1:0]     slot_counter;
  logic [PIN_COUNT-1:0]  level_reg;
  logic [SLOT_W-1:0]     clr_addr;

  // tick stage waiting on read data
  logic                  p1_valid;
  logic [SLOT_W-1:0]     p1_slot;

  // captured edit request
  op_t                   e_op;
  logic                  e_pin_ok;
  logic [PIN_COUNT-1:0]  e_bit;
  logic [SLOT_W-1:0]     e_start;
  logic [CNT_W-1:0]      e_len;
  logic [CNT_W-1:0]      e_sub;
  status_t               e_status;

  // remainder of slots_in_use by the sub-period, one bit per cycle
  logic [CNT_W-1:0]      rem;
  logic [DIV_CW-1:0]     div_cnt;
  logic [CNT_W-1:0]      div_shift;
  logic [CNT_W-1:0]      div_rem;

  // slot walker
  logic [SLOT_W-1:0]     wk_idx;
  logic [CNT_W-1:0]      wk_ph;
  logic [CNT_W-1:0]      wk_left;
  logic [CNT_W-1:0]      wk_wrap;
  logic [CNT_W-1:0]      wk_sub;
  logic [CNT_W-1:0]      wk_len;
  logic                  wk_wipe;
  act_t                  wk_act;
  logic [CNT_W-1:0]      wk_idx_inc;
  logic [SLOT_W-1:0]     wk_idx_next;
  logic [CNT_W-1:0]      wk_ph_inc;
  logic [CNT_W-1:0]      wk_ph_next;

  // write back stage
  logic                  w_valid;
  logic [SLOT_W-1:0]     w_addr;
  act_t                  w_act;

  // edit check results
  status_t               chk_status;
  logic                  chk_walk;
  logic                  chk_wipe;
  logic [SLOT_W-1:0]     chk_start;
  logic [CNT_W-1:0]      chk_sub;
  logic [CNT_W-1:0]      chk_len;
  logic [CNT_W-1:0]      chk_wrap;

  // handshake and tick helpers
  logic                  accept;
  logic                  out_free;
  logic [SLOT_W-1:0]     play_slot;
  logic [CNT_W-1:0]      play_inc;
  logic [SLOT_W-1:0]     slot_after;
  logic [CNT_W-1:0]      cfg_clamped;
  logic                  req_pin_ok;

  // memory port
  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic                  ram_re;
  logic [SLOT_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]    ram_rdata;
  logic [PIN_COUNT-1:0]  rd_set;
  logic [PIN_COUNT-1:0]  rd_clr;
  logic [PIN_COUNT-1:0]  new_set;
  logic [PIN_COUNT-1:0]  new_clr;
  logic [PIN_COUNT-1:0]  level_tick;

  // ---------------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------------
  assign accept    = req_valid && !req_stall;
  assign out_free  = !res_valid || !res_stall;
  // a tick may enter while the previous one moves on to the output register
  assign req_stall = (state != S_IDLE) || (p1_valid && !out_free);

  assign req_pin_ok = {1'b0, req.pin} < (PIN_W + 1)'(PIN_COUNT);

  // register writes are clamped into 1 .. MAX_SLOTS
  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_clamped = CNT_W'(1);
    end else if (cfg_wr_data > CNT_W'(MAX_SLOTS)) begin
      cfg_clamped = CNT_W'(MAX_SLOTS);
    end else begin
      cfg_clamped = cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // tick: a counter beyond a shrunk period plays slot 0
  // ---------------------------------------------------------------------------
  assign play_slot  = ({1'b0, slot_counter} >= slots_in_use) ? '0 : slot_counter;
  assign play_inc   = {1'b0, play_slot} + CNT_W'(1);
  assign slot_after = (play_inc >= slots_in_use) ? '0 : play_inc[SLOT_W-1:0];

  assign rd_set     = ram_rdata[ENTRY_W-1:PIN_COUNT];
  assign rd_clr     = ram_rdata[PIN_COUNT-1:0];
  assign level_tick = (level_reg | rd_set) & ~rd_clr;

  // ---------------------------------------------------------------------------
  // remainder step
  // ---------------------------------------------------------------------------
  assign div_shift = {rem[CNT_W-2:0], slots_in_use[div_cnt]};
  assign div_rem   = (div_shift >= e_sub) ? (div_shift - e_sub) : div_shift;

  // ---------------------------------------------------------------------------
  // edit checks, in the order length, start for a single pulse and
  // sub-period, start, length for a repeated one
  // ---------------------------------------------------------------------------
  always_comb begin
    chk_status = ST_OK;
    chk_walk   = 1'b0;
    chk_wipe   = 1'b0;
    chk_start  = e_start;
    chk_sub    = slots_in_use;
    chk_len    = e_len;
    case (e_op)
      OP_PULSE: begin
        if (e_pin_ok && e_len != '0) begin
          if (e_len > slots_in_use) begin
            chk_status = ST_LEN;
          end else if ({1'b0, e_start} >= slots_in_use) begin
            chk_status = ST_START;
          end else begin
            chk_walk = 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        if (e_pin_ok) begin
          chk_walk  = 1'b1;
          chk_wipe  = 1'b1;
          chk_start = '0;
          chk_sub   = CNT_W'(MAX_SLOTS);
        end
      end
      OP_REPEAT: begin
        if (e_pin_ok) begin
          if (e_sub == '0 || rem != '0) begin
            chk_status = ST_SUB;
          end else if ({1'b0, e_start} >= e_sub) begin
            chk_status = ST_START;
          end else if (e_len > e_sub) begin
            chk_status = ST_LEN;
          end else if (e_len == e_sub) begin
            // always on: one pulse over the whole period from slot 0
            chk_walk  = 1'b1;
            chk_start = '0;
            chk_len   = slots_in_use;
          end else if (e_len != '0) begin
            chk_walk = 1'b1;
            chk_sub  = e_sub;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // clear pin covers every table entry, pulses only the slots in use
  assign chk_wrap = chk_wipe ? CNT_W'(MAX_SLOTS) : slots_in_use;

  // ---------------------------------------------------------------------------
  // slot walker: the phase restarts at every sub-period, a single pulse uses
  // the whole period as its sub-period
  // ---------------------------------------------------------------------------
  always_comb begin
    if (wk_wipe) begin
      wk_act = ACT_MID;
    end else if (wk_ph == '0) begin
      wk_act = ACT_SET;
    end else if (wk_ph < wk_len) begin
      wk_act = ACT_MID;
    end else if (wk_ph == wk_len) begin
      wk_act = ACT_END;
    end else begin
      wk_act = ACT_NONE;
    end
  end

  assign wk_idx_inc  = {1'b0, wk_idx} + CNT_W'(1);
  assign wk_idx_next = (wk_idx_inc >= wk_wrap) ? '0 : wk_idx_inc[SLOT_W-1:0];
  assign wk_ph_inc   = wk_ph + CNT_W'(1);
  assign wk_ph_next  = (wk_ph_inc == wk_sub) ? '0 : wk_ph_inc;

  // ---------------------------------------------------------------------------
  // write back: read data belongs to w_addr, walked slots never repeat so no
  // forwarding is needed
  // ---------------------------------------------------------------------------
  always_comb begin
    case (w_act)
      ACT_SET: begin
        new_set = rd_set | e_bit;
        new_clr = rd_clr & ~e_bit;
      end
      ACT_MID: begin
        new_set = rd_set & ~e_bit;
        new_clr = rd_clr & ~e_bit;
      end
      ACT_END: begin
        new_set = rd_set & ~e_bit;
        new_clr = rd_clr | e_bit;
      end
      default: begin
        new_set = rd_set;
        new_clr = rd_clr;
      end
    endcase
  end

  assign ram_we    = (state == S_CLEAR) || (w_valid && w_act != ACT_NONE);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : w_addr;
  assign ram_wdata = (state == S_CLEAR) ? '0 : {new_set, new_clr};
  assign ram_re    = (accept && req.op == OP_TICK) || (state == S_WALK);
  assign ram_raddr = (state == S_WALK) ? wk_idx : play_slot;

  stpg_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // control and registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      p1_valid     <= 1'b0;
      res_valid    <= 1'b0;
      w_valid      <= 1'b0;
      level_reg    <= '0;
      slot_counter <= '0;
      slots_in_use <= CNT_W'(MAX_SLOTS);
    end else begin
      if (cfg_wr_en) begin
        slots_in_use <= cfg_clamped;
      end

      // a new result loads the output register, an accepted one empties it
      if ((p1_valid || state == S_DONE) && out_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end

      // tick result into the output register
      if (p1_valid && out_free) begin
        p1_valid       <= 1'b0;
        res.pin_levels <= LEVEL_W'(level_tick);
        res.slot       <= p1_slot;
        res.status     <= ST_OK;
        level_reg      <= level_tick;
      end

      w_valid <= (state == S_WALK);

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + SLOT_W'(1);
          if (clr_addr == SLOT_W'(MAX_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (req.op == OP_TICK) begin
              p1_valid     <= 1'b1;
              p1_slot      <= play_slot;
              slot_counter <= slot_after;
            end else begin
              e_op     <= req.op;
              e_pin_ok <= req_pin_ok;
              e_bit    <= PIN_COUNT'(1) << req.pin;
              e_start  <= req.start_slot;
              e_len    <= req.length_slots;
              e_sub    <= req.sub_period_slots;
              state    <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          // earlier ticks finish before the table is edited
          if (!p1_valid) begin
            if (e_op == OP_REPEAT) begin
              rem     <= '0;
              div_cnt <= DIV_CW'(CNT_W - 1);
              state   <= S_DIV;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_DIV: begin
          rem     <= div_rem;
          div_cnt <= div_cnt - DIV_CW'(1);
          if (div_cnt == '0) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          e_status <= chk_status;
          wk_idx   <= chk_start;
          wk_ph    <= '0;
          wk_sub   <= chk_sub;
          wk_len   <= chk_len;
          wk_wrap  <= chk_wrap;
          wk_left  <= chk_wrap;
          wk_wipe  <= chk_wipe;
          if (chk_wipe) begin
            level_reg <= level_reg & ~e_bit;
          end
          state <= chk_walk ? S_WALK : S_DONE;
        end
        S_WALK: begin
          w_addr  <= wk_idx;
          w_act   <= wk_act;
          wk_idx  <= wk_idx_next;
          wk_ph   <= wk_ph_next;
          wk_left <= wk_left - CNT_W'(1);
          if (wk_left == CNT_W'(1)) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          // last write back lands here
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            res.pin_levels <= LEVEL_W'(level_reg);
            res.slot       <= slot_counter;
            res.status     <= e_status;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_no_write_under_tick: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !p1_valid)
    else $error("table written while a tick waits on read data");

  a_walk_alone: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> !p1_valid && !req_stall == 1'b0)
    else $error("walk overlaps tick traffic");

  a_wb_in_edit: assert property (@(posedge clk) disable iff (rst)
    w_valid |-> (state == S_WALK || state == S_FLUSH))
    else $error("write back outside an edit");

  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    (p1_valid && out_free) |=> res_valid && res.status == ST_OK)
    else $error("tick result lost");

  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> req_stall)
    else $error("request accepted during table clearing");

endmodule
`default_nettype wire

// File: src/stpg_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stpg_ram
// simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module stpg_ram
  import stpg_pkg::*;
#(
  parameter int WIDTH = 2 * PIN_COUNT_DEF,
  parameter int DEPTH = MAX_SLOTS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
